// ===== design/binary_to_decimal_digits_defines.svh =====
// assertion macros for the binary to decimal digit converter
`ifndef BINARY_TO_DECIMAL_DIGITS_DEFINES_SVH
`define BINARY_TO_DECIMAL_DIGITS_DEFINES_SVH

`ifndef SYNTH
`define B2D_ASSERT(name, expr) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("b2d assertion failed");
`define B2D_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("b2d assertion failed");
`else
`define B2D_ASSERT(name, expr)
`define B2D_ASSERT_NEXT(name, pre, post)
`endif

`endif

// ===== design/b2dd_pkg.sv =====
// shared types, widths and helpers for the binary to decimal digit converter
package b2dd_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int IN_W            = 64;
    localparam int DIGIT_W         = 4;
    localparam int POS_W           = 5;
    localparam int COUNT_W         = 5;

    // decimal digits of 2^w - 1, floor(w * log10(2)) + 1
    function automatic int num_digits(input int w);
        return ((w * 1233) >> 12) + 1;
    endfunction

    typedef struct packed {
        logic clr;
        logic conv;
        logic move;
    } t_cell_ctl;

endpackage

// ===== design/b2dd_cell.sv =====
// one bcd digit cell of the shift-and-add-3 chain
module b2dd_cell
    import b2dd_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic               i_bit,
    input  logic [DIGIT_W-1:0] i_digit,
    output logic               o_bit,
    output logic [DIGIT_W-1:0] o_digit,
    output logic               o_nz
);

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] w_adj;

    assign w_adj   = (r_digit >= DIGIT_W'(5)) ? r_digit + DIGIT_W'(3) : r_digit;
    assign o_bit   = w_adj[DIGIT_W-1];
    assign o_digit = r_digit;
    assign o_nz    = (r_digit != '0);

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_digit <= '0;
        end else if (i_ctl.conv) begin
            r_digit <= {w_adj[DIGIT_W-2:0], i_bit};
        end else if (i_ctl.move) begin
            r_digit <= i_digit;
        end
    end

endmodule

// ===== design/binary_to_decimal_digits.sv =====
// top level: binary to decimal digit converter built on a chain of bcd cells
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+-----------------------------
//  request   | i_integer_part                          | start high, busy low
//  result    | o_digit o_position o_digit_count        | o_valid strobe, one cycle
//            | o_is_zero o_last                        |
//
// a request shifts VALUE_WIDTH bits through the cell chain, then a settle step, then
// alignment of the top nonzero digit into the last cell and digit output; a zero value
// skips the alignment. results leave in the cycle after each output step, back to
// back. reset clears the control state only. the receiver cannot stall, so a run of
// results is never interrupted.
`include "binary_to_decimal_digits_defines.svh"

module binary_to_decimal_digits
    import b2dd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [IN_W-1:0]    i_integer_part,
    output logic               busy,
    output logic               o_valid,
    output logic [DIGIT_W-1:0] o_digit,
    output logic [POS_W-1:0]   o_position,
    output logic [COUNT_W-1:0] o_digit_count,
    output logic               o_is_zero,
    output logic               o_last
);

    localparam int NUM_DIGITS = num_digits(VALUE_WIDTH);
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
    localparam int STEP_W     = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SETTLE,
        S_ALIGN,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [STEP_W-1:0]      r_step;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [CNT_W-1:0]       r_pos;
    logic                   r_valid;
    logic [DIGIT_W-1:0]     r_digit;
    logic [POS_W-1:0]       r_position;
    logic [COUNT_W-1:0]     r_digit_count;
    logic                   r_is_zero;
    logic                   r_last;

    t_cell_ctl              w_ctl;
    logic                   w_accept;
    logic                   w_emit_last;
    logic [NUM_DIGITS-1:0]  w_cout;
    logic [NUM_DIGITS-1:0]  w_nz;
    logic [DIGIT_W-1:0]     w_digit [NUM_DIGITS];

    assign w_accept    = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign w_emit_last = (r_count == '0) || (r_pos == r_count - CNT_W'(1));

    always_comb begin
        w_ctl.clr  = w_accept;
        w_ctl.conv = (r_state == S_CONV);
        w_ctl.move = (r_state == S_EMIT) ||
                     ((r_state == S_ALIGN) && (r_count != '0) && !w_nz[NUM_DIGITS-1]);
    end

    // digit count grows by at most one per shift step
    always_comb begin
        n_count = r_count;
        if ((r_count < CNT_W'(NUM_DIGITS)) && w_nz[r_count[IDX_W-1:0]]) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        logic               w_bit_in;
        logic [DIGIT_W-1:0] w_digit_in;
        if (g == 0) begin : g_first
            assign w_bit_in   = r_value[VALUE_WIDTH-1];
            assign w_digit_in = '0;
        end else begin : g_rest
            assign w_bit_in   = w_cout[g-1];
            assign w_digit_in = w_digit[g-1];
        end
        b2dd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_bit   (w_bit_in),
            .i_digit (w_digit_in),
            .o_bit   (w_cout[g]),
            .o_digit (w_digit[g]),
            .o_nz    (w_nz[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (r_step == '0) begin
                        r_state <= S_SETTLE;
                    end
                end
                S_SETTLE: begin
                    r_state <= S_ALIGN;
                end
                S_ALIGN: begin
                    if ((r_count == '0) || w_nz[NUM_DIGITS-1]) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_valid <= 1'b1;
                    if (w_emit_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end

        if (w_accept) begin
            r_value <= i_integer_part[VALUE_WIDTH-1:0];
            r_step  <= STEP_W'(VALUE_WIDTH - 1);
            r_count <= '0;
            r_pos   <= '0;
        end else if (r_state == S_CONV) begin
            r_value <= {r_value[VALUE_WIDTH-2:0], 1'b0};
            r_step  <= r_step - STEP_W'(1);
            r_count <= n_count;
        end else if (r_state == S_SETTLE) begin
            r_count <= n_count;
        end else if (r_state == S_EMIT) begin
            r_pos <= r_pos + CNT_W'(1);
        end

        if (r_state == S_EMIT) begin
            r_digit       <= w_digit[NUM_DIGITS-1];
            r_position    <= POS_W'(r_pos);
            r_digit_count <= COUNT_W'(r_count);
            r_is_zero     <= (r_count == '0);
            r_last        <= w_emit_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_digit       = r_digit;
    assign o_position    = r_position;
    assign o_digit_count = r_digit_count;
    assign o_is_zero     = r_is_zero;
    assign o_last        = r_last;

    `B2D_ASSERT(a_no_overflow, (r_state != S_CONV) || !w_cout[NUM_DIGITS-1])
    `B2D_ASSERT(a_count_range, (r_state == S_IDLE) || (r_count <= CNT_W'(NUM_DIGITS)))
    `B2D_ASSERT_NEXT(a_run_contiguous, o_valid && !o_last, o_valid)
    `B2D_ASSERT_NEXT(a_run_ends, o_valid && o_last, !o_valid)
    `B2D_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

endmodule

// ===== sim/b2dd_digit_monitor.sv =====
`timescale 1ns / 1ps
// digit predictor and result comparison for the binary to decimal digit converter
module b2dd_digit_monitor
    import b2dd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [IN_W-1:0]    i_integer_part,
    input  logic               o_valid,
    input  logic [DIGIT_W-1:0] o_digit,
    input  logic [POS_W-1:0]   o_position,
    input  logic [COUNT_W-1:0] o_digit_count,
    input  logic               o_is_zero,
    input  logic               o_last,
    output int                 o_mismatches,
    output int                 o_pending
);

    localparam int DECIMAL_BASE  = 10;
    localparam int MAX_DIGITS    = 20;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [IN_W-1:0] VALUE_MASK = (VALUE_WIDTH >= IN_W) ? {IN_W{1'b1}} :
        ({{(IN_W-1){1'b0}}, 1'b1} << VALUE_WIDTH) - 1'b1;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] digit_count;
        logic               is_zero;
        logic               last;
    } t_digit_result;

    t_digit_result expected_digits[$];
    t_digit_result got;
    t_digit_result want;
    int            mismatch_cnt = 0;

    function automatic void queue_digits(input logic [IN_W-1:0] value);
        logic [IN_W-1:0]    rest;
        logic [DIGIT_W-1:0] rev [MAX_DIGITS];
        int                 n;
        t_digit_result      r;
        rest = value & VALUE_MASK;
        n    = 0;
        if (rest == '0) begin
            r = '{digit: '0, position: '0, digit_count: '0, is_zero: 1'b1, last: 1'b1};
            expected_digits.push_back(r);
            return;
        end
        while (rest != '0 && n < MAX_DIGITS) begin
            rev[n] = DIGIT_W'(rest % DECIMAL_BASE);
            rest   = rest / DECIMAL_BASE;
            n++;
        end
        for (int k = 0; k < n; k++) begin
            r.digit       = rev[n-1-k];
            r.position    = POS_W'(k);
            r.digit_count = COUNT_W'(n);
            r.is_zero     = 1'b0;
            r.last        = (k == n - 1);
            expected_digits.push_back(r);
        end
    endfunction

    function automatic string show(input t_digit_result r);
        return $sformatf("digit %0d pos %0d count %0d zero %0b last %0b",
                         r.digit, r.position, r.digit_count, r.is_zero, r.last);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                got = '{digit: o_digit, position: o_position, digit_count: o_digit_count,
                        is_zero: o_is_zero, last: o_last};
                if (expected_digits.size() == 0) begin
                    if (mismatch_cnt < REPORT_LIMIT)
                        $display("%0t: digit result with no request pending: %s",
                                 $time, show(got));
                    mismatch_cnt++;
                end else begin
                    want = expected_digits.pop_front();
                    if (got !== want) begin
                        if (mismatch_cnt < REPORT_LIMIT)
                            $display("%0t: digit mismatch: expected %s, got %s",
                                     $time, show(want), show(got));
                        mismatch_cnt++;
                    end
                end
            end
            if (start && !busy)
                queue_digits(i_integer_part);
        end
        o_mismatches = mismatch_cnt;
        o_pending    = expected_digits.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// clock, reset, request stimulus and verdict for the binary to decimal digit converter
module tb_top;
    import b2dd_pkg::*;

    localparam int VALUE_WIDTH      = VALUE_WIDTH_DEF;
    localparam int IDLE_LIMIT       = 2000;
    localparam int DRAIN_CYCLES     = 100;
    localparam int RANDOM_PER_PHASE = 40;
    localparam int NUM_CORNERS      = 17;
    localparam int NUM_PHASES       = 4;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic [IN_W-1:0]    i_integer_part;
    logic               busy;
    logic               o_valid;
    logic [DIGIT_W-1:0] o_digit;
    logic [POS_W-1:0]   o_position;
    logic [COUNT_W-1:0] o_digit_count;
    logic               o_is_zero;
    logic               o_last;

    int mismatches;
    int pending;
    int idle_cycles = 0;
    int sender_idle_pct;

    logic [IN_W-1:0] corner_values [NUM_CORNERS] = '{
        64'd0, 64'd1, 64'd9, 64'd10, 64'd11, 64'd99, 64'd100, 64'd1000000000,
        64'd4294967295, 64'd9223372036854775807, 64'd9223372036854775808,
        64'd9999999999999999999, 64'd10000000000000000000, 64'd12345678901234567890,
        64'd18446744073709551606, 64'd18446744073709551615, 64'd0
    };
    int idle_plan [NUM_PHASES] = '{0, 87, 0, 14};

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    binary_to_decimal_digits #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_integer_part(i_integer_part),
        .busy          (busy),
        .o_valid       (o_valid),
        .o_digit       (o_digit),
        .o_position    (o_position),
        .o_digit_count (o_digit_count),
        .o_is_zero     (o_is_zero),
        .o_last        (o_last)
    );

    b2dd_digit_monitor #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_integer_part(i_integer_part),
        .o_valid       (o_valid),
        .o_digit       (o_digit),
        .o_position    (o_position),
        .o_digit_count (o_digit_count),
        .o_is_zero     (o_is_zero),
        .o_last        (o_last),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [IN_W-1:0] value);
        if (sender_idle_pct > 0 && $urandom_range(3) == 0) begin
            start <= 1'b0;
            @(negedge i_clk);
            while (busy) @(negedge i_clk);
        end
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start          <= 1'b1;
        i_integer_part <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        logic [IN_W-1:0] value;
        logic [IN_W-1:0] power;
        start           = 1'b0;
        i_integer_part  = '0;
        i_rst_n         = 1'b0;
        sender_idle_pct = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (corner_values[i])
            send_request(corner_values[i]);

        foreach (idle_plan[p]) begin
            sender_idle_pct = idle_plan[p];
            repeat (RANDOM_PER_PHASE) begin
                value = {$urandom, $urandom};
                case ($urandom_range(5))
                    0: value = value >> $urandom_range(63);
                    1: value = value >> $urandom_range(63, 40);
                    2: begin
                        power = 64'd1;
                        repeat ($urandom_range(19)) power = power * 64'd10;
                        value = power + $urandom_range(2) - 1;
                    end
                    3: if ($urandom_range(3) == 0) value = '0;
                    default: ;
                endcase
                send_request(value);
            end
        end

        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
